// File: rtl/dws_pkg.sv
package dws_pkg;

  localparam int MaxItems   = 64;
  localparam int WeightBits = 32;
  localparam int TagBits    = 16;

  typedef struct packed {
    logic [WeightBits-1:0] weight;
    logic [TagBits-1:0]    tag;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } cell_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic shift;
  } ctrl_t;

  typedef enum logic {
    StLoad,
    StDrain
  } state_e;

endpackage

// File: rtl/descending_weight_sorter_top.sv
// Loading: one input transfer per cycle; each item is placed in its sorted slot
// by the cell chain in the cycle it is taken.
// The first result is offered the cycle after the transfer flagged last, then
// one result per cycle while out_stall_i is low.
// The input is stalled while the chain is being drained.
// Reset empties the chain, clears the overflow flag and returns to loading.
module descending_weight_sorter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dws_pkg::WeightBits-1:0]   item_weight_i,
  input  logic [dws_pkg::TagBits-1:0]      item_tag_i,
  input  logic                             set_last_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [dws_pkg::WeightBits-1:0]   out_weight_o,
  output logic [dws_pkg::TagBits-1:0]      out_tag_o,
  output logic                             out_last_o,
  output logic                             overflow_o
);
  import dws_pkg::*;

  state_e state_q, state_d;
  logic   ovf_q, ovf_d;
  logic   in_xfer, out_xfer, full;
  ctrl_t  ctrl;
  item_t  new_item;
  cell_t  cells [MaxItems];
  logic   takes [MaxItems];

  assign new_item.weight = item_weight_i;
  assign new_item.tag    = item_tag_i;

  assign in_stall_o  = (state_q == StDrain);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StDrain);
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign full        = cells[MaxItems-1].valid;

  assign ctrl.insert = in_xfer && !full;
  assign ctrl.shift  = out_xfer;

  for (genvar i = 0; i < MaxItems; i++) begin : g_cell
    cell_t prev_c, next_c;
    logic  prev_take;
    if (i == 0) begin : g_head
      assign prev_c    = '0;
      assign prev_take = 1'b0;
    end else begin : g_body
      assign prev_c    = cells[i-1];
      assign prev_take = takes[i-1];
    end
    if (i == MaxItems - 1) begin : g_tail
      assign next_c = '0;
    end else begin : g_inner
      assign next_c = cells[i+1];
    end

    dws_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_i      (new_item),
      .prev_i     (prev_c),
      .prev_take_i(prev_take),
      .next_i     (next_c),
      .cell_o     (cells[i]),
      .take_o     (takes[i])
    );
  end

  assign out_weight_o = cells[0].item.weight;
  assign out_tag_o    = cells[0].item.tag;
  assign out_last_o   = !cells[1].valid;
  assign overflow_o   = ovf_q;

  always_comb begin
    state_d = state_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      StLoad: begin
        // A transfer that finds the chain full is dropped but still counts.
        if (in_xfer && full) begin
          ovf_d = 1'b1;
        end
        if (in_xfer && set_last_i) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (out_xfer && out_last_o) begin
          state_d = StLoad;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
    end
  end

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |-> cells[0].valid)
    else $error("drain with an empty head cell");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cells[1].valid |-> (cells[0].valid &&
                        cells[0].item.weight >= cells[1].item.weight))
    else $error("head cells out of order");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_last_o) |=> (!cells[0].valid && state_q == StLoad))
    else $error("chain not empty after the final transfer");

  a_overflow_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && full) |=> ovf_q)
    else $error("dropped item did not raise overflow");

endmodule

// File: rtl/dws_cell.sv
module dws_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dws_pkg::ctrl_t ctrl_i,
  input  dws_pkg::item_t new_i,
  input  dws_pkg::cell_t prev_i,
  input  logic           prev_take_i,
  input  dws_pkg::cell_t next_i,
  output dws_pkg::cell_t cell_o,
  output logic           take_o
);
  import dws_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;

  // The new item belongs at or before this cell when the cell is empty or
  // holds a weight that is not larger. Ties put the newer item first.
  assign take_o = !valid_q || (new_i.weight >= item_q.weight);

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (ctrl_i.insert) begin
      if (prev_take_i) begin
        valid_d = prev_i.valid;
        item_d  = prev_i.item;
      end else if (take_o) begin
        valid_d = 1'b1;
        item_d  = new_i;
      end
    end else if (ctrl_i.shift) begin
      valid_d = next_i.valid;
      item_d  = next_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.item  = item_q;

endmodule
